// ===== hdl/artdmx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package artdmx_pkg;

   // Fixed header length of an ArtDmx packet; channel data starts here.
   localparam int unsigned HEADER_BYTES = 18;

   // Byte offsets inside the Art-Net header.
   localparam logic [15:0] POS_OPCODE_LO = 16'd8;
   localparam logic [15:0] POS_OPCODE_HI = 16'd9;
   localparam logic [15:0] POS_FLAGS     = 16'd12;
   localparam logic [15:0] POS_UNIV_LO   = 16'd14;
   localparam logic [15:0] POS_UNIV_HI   = 16'd15;
   localparam logic [15:0] POS_LEN_HI    = 16'd16;
   localparam logic [15:0] POS_LEN_LO    = 16'd17;
   localparam logic [15:0] POS_IDENT_END = 16'd8;
   localparam logic [15:0] POS_DATA      = 16'(HEADER_BYTES);
   localparam logic [15:0] POS_MAX       = 16'hFFFF;

   // Opcodes (little-endian on the wire).
   localparam logic [15:0] OP_DMX        = 16'h5000;
   localparam logic [15:0] OP_POLL       = 16'h2000;
   localparam logic [15:0] OP_POLL_REPLY = 16'h2100;

   // Configuration register indexes.
   localparam logic CSR_LISTEN_UNIVERSE = 1'b0;
   localparam logic CSR_FILTER_ENABLE   = 1'b1;

   // Depth of the command queue between front and back.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      EV_CHANNEL    = 2'd0,
      EV_FRAME_END  = 2'd1,
      EV_POLL       = 2'd2,
      EV_POLL_REPLY = 2'd3
   } event_kind_type;

   // One command per input byte that produces at least one event.
   typedef struct packed {
      logic           has_chan;
      logic [8:0]     chan_index;
      logic [7:0]     chan_value;
      logic           has_end;
      event_kind_type end_kind;
      logic [15:0]    universe;
      logic [9:0]     frame_len;
      logic [7:0]     talk_to_me;
      logic [31:0]    source;
   } cmd_type;

   // Queue status seen by the front and the back.
   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   // The identifier "Art-Net" followed by a zero byte.
   function automatic logic [7:0] ident_byte(input logic [2:0] idx);
      logic [7:0] value;
      unique case (idx)
         3'd0:    value = 8'h41;
         3'd1:    value = 8'h72;
         3'd2:    value = 8'h74;
         3'd3:    value = 8'h2D;
         3'd4:    value = 8'h4E;
         3'd5:    value = 8'h65;
         3'd6:    value = 8'h74;
         default: value = 8'h00;
      endcase
      return value;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/artnet_dmx_packet_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Contents
// req_      in         req_tvalid/req_tready  one payload byte, end flag, sender address
// rsp_      out        rsp_tvalid/rsp_tready  one event: channel, frame end, poll, reply
// csr_      in         csr_we                 listen universe and filter enable
//
// One payload byte is taken per cycle while the queue is not full; parsing is a
// byte counter and compares. The front decodes each byte in the cycle it is
// accepted and writes at most one command into a four-entry queue; the back
// turns a command into one or two events through a registered output stage, one
// event per cycle while rsp_tready is high. A byte whose datagram ends on a DMX
// channel yields two events. req_tready drops only when the queue is full; reset
// is synchronous and clears the packet state, the queue and the output stage.

module artnet_dmx_packet_parser import artdmx_pkg::*; #(
   parameter int unsigned CHANNELS = 512
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [7:0] payload_byte, [39:8] sender_ip
   input  wire logic [39:0] req_tdata,
   input  wire logic        req_tlast,

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [8:0] channel_index, [16:9] channel_value, [32:17] universe_number,
   // [42:33] frame_length, [50:43] talk_to_me, [82:51] source_address,
   // [87:83] zero
   output logic [87:0]      rsp_tdata,
   // [1:0] event_kind
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast,

   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);

   // Configuration registers. Users must write only while the block is idle; unchecked.
   logic [15:0] listen_universe_ff;
   logic        filter_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         listen_universe_ff <= '0;
         filter_enable_ff   <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LISTEN_UNIVERSE: listen_universe_ff <= csr_wdata;
            CSR_FILTER_ENABLE:   filter_enable_ff   <= csr_wdata[0];
            default:             ;
         endcase
      end
   end

   // Front to back command path.
   logic             fifo_push;
   cmd_type          fifo_push_cmd;
   logic             fifo_pop;
   cmd_type          fifo_head;
   queue_status_type fifo_status;

   // The front decodes the header and emits a command for every byte that
   // produces an event.
   artdmx_front #(
      .CHANNELS(CHANNELS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_tvalid),
      .in_ready        (req_tready),
      .in_byte         (req_tdata[7:0]),
      .in_last         (req_tlast),
      .in_ip           (req_tdata[39:8]),
      .listen_universe (listen_universe_ff),
      .filter_enable   (filter_enable_ff),
      .queue_status    (fifo_status),
      .push            (fifo_push),
      .push_cmd        (fifo_push_cmd)
   );

   artdmx_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (fifo_push),
      .push_cmd (fifo_push_cmd),
      .pop      (fifo_pop),
      .head     (fifo_head),
      .status   (fifo_status)
   );

   // The back splits each command into its events and holds the result
   // in an output register so a stalled consumer never blocks the front
   // until the queue fills.
   artdmx_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (fifo_head),
      .queue_status (fifo_status),
      .pop          (fifo_pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_data     (rsp_tdata),
      .out_kind     (rsp_tuser),
      .out_last     (rsp_tlast)
   );

   // The front must never push into a full queue.
   assert property (@(posedge clock) disable iff (reset)
      fifo_push |-> !fifo_status.full)
      else $error("command pushed into a full queue");

   // A channel event that is not the last of its byte is followed at once by
   // the frame end of the same packet.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast)
         |=> (rsp_tvalid && rsp_tuser == EV_FRAME_END))
      else $error("channel event not followed by its frame end");

   // Frame length never exceeds the channel limit.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == EV_FRAME_END)
         |-> ({22'd0, rsp_tdata[42:33]} <= 32'(CHANNELS)))
      else $error("frame length beyond channel limit");

   // Channel indexes stay below the channel limit.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == EV_CHANNEL)
         |-> ({23'd0, rsp_tdata[8:0]} < 32'(CHANNELS)))
      else $error("channel index beyond channel limit");

endmodule

`default_nettype wire

// ===== hdl/artdmx_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module artdmx_front import artdmx_pkg::*; #(
   parameter int unsigned CHANNELS = 512
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [7:0]       in_byte,
   input  wire logic             in_last,
   input  wire logic [31:0]      in_ip,
   input  wire logic [15:0]      listen_universe,
   input  wire logic             filter_enable,
   input  wire queue_status_type queue_status,
   output logic                  push,
   output cmd_type               push_cmd
);

   localparam logic [15:0] CHAN_LIMIT = 16'(CHANNELS);

   logic [15:0] byte_position_ff, byte_position_in;
   logic        ident_ok_ff, ident_ok_in;
   logic [15:0] opcode_ff, opcode_in;
   logic [15:0] universe_ff, universe_in;
   logic [15:0] length_ff, length_in;
   logic [7:0]  flags_ff, flags_in;
   logic [31:0] source_ff, source_in;
   logic [9:0]  sent_ff, sent_in;
   logic        accept_dmx_ff, accept_dmx_in;

   logic        accept;
   logic [15:0] limit;
   logic [15:0] count;
   cmd_type     cmd;

   assign in_ready = !queue_status.full;
   assign accept   = in_valid && in_ready;
   assign limit    = (length_ff < CHAN_LIMIT) ? length_ff : CHAN_LIMIT;

   always_comb begin
      byte_position_in = byte_position_ff;
      ident_ok_in      = ident_ok_ff;
      opcode_in        = opcode_ff;
      universe_in      = universe_ff;
      length_in        = length_ff;
      flags_in         = flags_ff;
      source_in        = source_ff;
      sent_in          = sent_ff;
      accept_dmx_in    = accept_dmx_ff;
      cmd              = '0;
      count            = byte_position_ff;

      if (byte_position_ff == '0) begin
         source_in = in_ip;
      end
      if (byte_position_ff < POS_IDENT_END &&
          in_byte != ident_byte(byte_position_ff[2:0])) begin
         ident_ok_in = 1'b0;
      end

      if (byte_position_ff == POS_OPCODE_LO) begin
         opcode_in[7:0] = in_byte;
      end
      if (byte_position_ff == POS_OPCODE_HI) begin
         opcode_in[15:8] = in_byte;
      end
      if (byte_position_ff == POS_FLAGS) begin
         flags_in = in_byte;
      end
      if (byte_position_ff == POS_UNIV_LO) begin
         universe_in[7:0] = in_byte;
      end
      if (byte_position_ff == POS_UNIV_HI) begin
         universe_in[15:8] = in_byte;
      end
      if (byte_position_ff == POS_LEN_HI) begin
         length_in[15:8] = in_byte;
      end
      if (byte_position_ff == POS_LEN_LO) begin
         length_in[7:0] = in_byte;
         accept_dmx_in  = ident_ok_in && opcode_ff == OP_DMX &&
                          (!filter_enable || universe_ff == listen_universe);
      end

      // Channel bytes follow the header while the frame limit is not reached.
      if (byte_position_ff >= POS_DATA && accept_dmx_ff &&
          {6'd0, sent_ff} < limit) begin
         cmd.has_chan   = 1'b1;
         cmd.chan_index = sent_ff[8:0];
         cmd.chan_value = in_byte;
         sent_in        = sent_ff + 10'd1;
      end

      if (byte_position_ff != POS_MAX) begin
         byte_position_in = byte_position_ff + 16'd1;
      end
      count = byte_position_in;

      // A packet long enough to hold the whole header has already passed
      // the flags byte, so the poll flags are always present here.
      if (in_last && count >= POS_DATA && ident_ok_in) begin
         if (opcode_in == OP_DMX) begin
            if (accept_dmx_in) begin
               cmd.has_end   = 1'b1;
               cmd.end_kind  = EV_FRAME_END;
               cmd.frame_len = sent_in;
            end
         end else if (opcode_in == OP_POLL) begin
            cmd.has_end    = 1'b1;
            cmd.end_kind   = EV_POLL;
            cmd.talk_to_me = flags_in;
         end else if (opcode_in == OP_POLL_REPLY) begin
            cmd.has_end  = 1'b1;
            cmd.end_kind = EV_POLL_REPLY;
         end
      end
      cmd.universe = universe_in;
      cmd.source   = source_in;

      if (in_last) begin
         byte_position_in = '0;
         ident_ok_in      = 1'b1;
         opcode_in        = '0;
         universe_in      = '0;
         length_in        = '0;
         flags_in         = '0;
         source_in        = '0;
         sent_in          = '0;
         accept_dmx_in    = 1'b0;
      end
   end

   assign push     = accept && (cmd.has_chan || cmd.has_end);
   assign push_cmd = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff <= '0;
         ident_ok_ff      <= 1'b1;
         opcode_ff        <= '0;
         universe_ff      <= '0;
         length_ff        <= '0;
         flags_ff         <= '0;
         source_ff        <= '0;
         sent_ff          <= '0;
         accept_dmx_ff    <= 1'b0;
      end else if (accept) begin
         byte_position_ff <= byte_position_in;
         ident_ok_ff      <= ident_ok_in;
         opcode_ff        <= opcode_in;
         universe_ff      <= universe_in;
         length_ff        <= length_in;
         flags_ff         <= flags_in;
         source_ff        <= source_in;
         sent_ff          <= sent_in;
         accept_dmx_ff    <= accept_dmx_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/artdmx_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module artdmx_queue import artdmx_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output cmd_type      head,
   output queue_status_type status
);

   cmd_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]       fill_ff, fill_in;
   logic                    do_push, do_pop;

   assign status.empty = (fill_ff == '0);
   assign status.full  = (fill_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/artdmx_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module artdmx_back import artdmx_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cmd_type          head,
   input  wire queue_status_type queue_status,
   output logic                  pop,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic [87:0]           out_data,
   output logic [1:0]            out_kind,
   output logic                  out_last
);

   logic           valid_ff, valid_in;
   logic [87:0]    data_ff, data_in;
   event_kind_type kind_ff, kind_in;
   logic           last_ff, last_in;
   logic           chan_done_ff, chan_done_in;
   logic           load;

   logic [8:0]     f_index;
   logic [7:0]     f_value;
   logic [15:0]    f_universe;
   logic [9:0]     f_frame_len;
   logic [7:0]     f_talk;

   assign load = !valid_ff || out_ready;

   always_comb begin
      valid_in     = valid_ff;
      kind_in      = kind_ff;
      last_in      = last_ff;
      chan_done_in = chan_done_ff;
      pop          = 1'b0;
      f_index      = '0;
      f_value      = '0;
      f_universe   = '0;
      f_frame_len  = '0;
      f_talk       = '0;

      if (load) begin
         valid_in = !queue_status.empty;
         if (!queue_status.empty) begin
            if (head.has_chan && !chan_done_ff) begin
               // Channel event goes first; a frame end in the same command
               // stays at the head for the next slot.
               kind_in    = EV_CHANNEL;
               f_index    = head.chan_index;
               f_value    = head.chan_value;
               f_universe = head.universe;
               last_in    = !head.has_end;
               if (head.has_end) begin
                  chan_done_in = 1'b1;
               end else begin
                  pop = 1'b1;
               end
            end else begin
               kind_in      = head.end_kind;
               last_in      = 1'b1;
               pop          = 1'b1;
               chan_done_in = 1'b0;
               if (head.end_kind == EV_FRAME_END) begin
                  f_universe  = head.universe;
                  f_frame_len = head.frame_len;
               end
               if (head.end_kind == EV_POLL) begin
                  f_talk = head.talk_to_me;
               end
            end
         end
      end

      data_in = load ? {5'd0, head.source, f_talk, f_frame_len, f_universe,
                        f_value, f_index} : data_ff;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      kind_ff <= kind_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         chan_done_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         chan_done_ff <= chan_done_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign out_kind  = kind_ff;
   assign out_last  = last_ff;

endmodule

`default_nettype wire
